[src/wrbf_pkg.sv]
// Package for the Wu RBF kernel sampler: widths, constants, register indexes.
// No dependencies.
package wrbf_pkg;
   localparam int FRAC_BITS = 16;
   localparam int CRD_W = 7;
   localparam int SUP_W = 6;
   localparam int OUT_W = 21;
   localparam int D2_W = 16;
   localparam int SQ_W = 24;
   localparam int T_W = FRAC_BITS + 1;
   localparam int RAD_W = 31;
   localparam int SQ_STEPS = SQ_W;
   localparam int SQ_PER_STG = 4;
   localparam int SQ_STAGES = SQ_STEPS / SQ_PER_STG;
   localparam int DIV_STEPS = 24;
   localparam int DIV_PER_STG = 4;
   localparam int DIV_STAGES = DIV_STEPS / DIV_PER_STG;
   localparam logic [T_W-1:0] ONE_FX = T_W'(1) << FRAC_BITS;
   localparam logic [OUT_W-1:0] OUT_MAX = '1;
   localparam logic [0:0] REG_SUPPORT = 1'b0;
   localparam logic [0:0] REG_SUPPORT_Z = 1'b1;

   typedef struct packed {
      logic [CRD_W-1:0] coord_x;
      logic [CRD_W-1:0] coord_y;
      logic [CRD_W-1:0] coord_z;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] kernel_value;
   } rsp_type;
endpackage

[src/wrbf_if.sv]
// Valid/ready channel interface carrying a request or response payload.
// Depends on wrbf_pkg.
interface wrbf_req_if import wrbf_pkg::*; (input logic clock);
   logic valid;
   logic ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface wrbf_rsp_if import wrbf_pkg::*; (input logic clock);
   logic valid;
   logic ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[src/wrbf_radius.sv]
// Pipelined radius unit: offsets, digit-recurrence square root and
// restoring division to normalised Q1.16 radii. Depends on wrbf_pkg.
module wrbf_radius import wrbf_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  req_type in_data,
   input  logic [SUP_W-1:0] support,
   input  logic [SUP_W-1:0] support_z,
   output logic out_valid,
   output logic [T_W-1:0] r_out,
   output logic [T_W-1:0] rz_out
);
   localparam int QW = DIV_STEPS;

   function automatic logic [CRD_W-1:0] absd(logic [CRD_W-1:0] a, logic [CRD_W-1:0] b);
      absd = (a >= b) ? (a - b) : (b - a);
   endfunction

   // stage 0: offsets and squared distance
   logic v0_ff;
   logic [D2_W-1:0] d2_ff;
   logic [CRD_W-1:0] dz_ff;
   logic [SUP_W-1:0] s0_ff, sz0_ff;
   logic [CRD_W-1:0] dx, dy, dz;
   logic [D2_W-1:0] d2_in;

   always_comb begin
      dx = absd(in_data.coord_x, CRD_W'(support));
      dy = absd(in_data.coord_y, CRD_W'(support));
      dz = absd(in_data.coord_z, CRD_W'(support));
      d2_in = D2_W'(dx * dx) + D2_W'(dy * dy) + D2_W'(dz * dz);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
      end
      if (en) begin
         d2_ff <= d2_in;
         dz_ff <= dz;
         s0_ff <= support;
         sz0_ff <= support_z;
      end
   end

   // square root of d2 << 32: root has 24 bits; operand bits beyond d2 are zero
   logic [SQ_STAGES:0] sv_ff;
   logic [D2_W-1:0] sd_ff [SQ_STAGES+1];
   logic [SQ_W+1:0] srem_ff [SQ_STAGES+1];
   logic [SQ_W-1:0] sroot_ff [SQ_STAGES+1];
   logic [CRD_W-1:0] sdz_ff [SQ_STAGES+1];
   logic [SUP_W-1:0] ss_ff [SQ_STAGES+1];
   logic [SUP_W-1:0] ssz_ff [SQ_STAGES+1];

   always_comb begin
      sv_ff[0] = v0_ff;
      sd_ff[0] = d2_ff;
      srem_ff[0] = '0;
      sroot_ff[0] = '0;
      sdz_ff[0] = dz_ff;
      ss_ff[0] = s0_ff;
      ssz_ff[0] = sz0_ff;
   end

   for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sq
      logic [SQ_W+1:0] rem_c;
      logic [SQ_W-1:0] root_c;
      logic [SQ_W+1:0] trial;
      logic [1:0] pair;
      logic [2*SQ_W-1:0] opnd;
      always_comb begin
         rem_c = srem_ff[g];
         root_c = sroot_ff[g];
         trial = '0;
         pair = '0;
         opnd = {sd_ff[g], (2*SQ_W-D2_W)'(0)};
         for (int k = 0; k < SQ_PER_STG; k++) begin
            pair = opnd[2*SQ_W-1-2*(g*SQ_PER_STG+k) -: 2];
            rem_c = {rem_c[SQ_W-1:0], pair};
            trial = {root_c, 2'b01};
            if (rem_c >= trial) begin
               rem_c = rem_c - trial;
               root_c = {root_c[SQ_W-2:0], 1'b1};
            end else begin
               root_c = {root_c[SQ_W-2:0], 1'b0};
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[g+1] <= 1'b0;
         end else if (en) begin
            sv_ff[g+1] <= sv_ff[g];
         end
         if (en) begin
            sd_ff[g+1] <= sd_ff[g];
            srem_ff[g+1] <= rem_c;
            sroot_ff[g+1] <= root_c;
            sdz_ff[g+1] <= sdz_ff[g];
            ss_ff[g+1] <= ss_ff[g];
            ssz_ff[g+1] <= ssz_ff[g];
         end
      end
   end

   // two restoring dividers side by side: root / support, (dz<<16) / support_z
   logic [DIV_STAGES:0] dv_ff;
   logic [SUP_W:0] ra_ff [DIV_STAGES+1];
   logic [SUP_W:0] za_ff [DIV_STAGES+1];
   logic [QW-1:0] rn_ff [DIV_STAGES+1];
   logic [QW-1:0] zn_ff [DIV_STAGES+1];
   logic [SUP_W-1:0] ds_ff [DIV_STAGES+1];
   logic [SUP_W-1:0] dsz_ff [DIV_STAGES+1];

   always_comb begin
      dv_ff[0] = sv_ff[SQ_STAGES];
      ra_ff[0] = '0;
      za_ff[0] = '0;
      rn_ff[0] = sroot_ff[SQ_STAGES];
      zn_ff[0] = QW'({sdz_ff[SQ_STAGES], FRAC_BITS'(0)});
      ds_ff[0] = ss_ff[SQ_STAGES];
      dsz_ff[0] = ssz_ff[SQ_STAGES];
   end

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      logic [SUP_W:0] ra_c, za_c;
      logic [QW-1:0] rn_c, zn_c;
      always_comb begin
         ra_c = ra_ff[g];
         za_c = za_ff[g];
         rn_c = rn_ff[g];
         zn_c = zn_ff[g];
         for (int k = 0; k < DIV_PER_STG; k++) begin
            ra_c = {ra_c[SUP_W-1:0], rn_c[QW-1]};
            rn_c = {rn_c[QW-2:0], 1'b0};
            if (ra_c >= {1'b0, ds_ff[g]}) begin
               ra_c = ra_c - {1'b0, ds_ff[g]};
               rn_c[0] = 1'b1;
            end
            za_c = {za_c[SUP_W-1:0], zn_c[QW-1]};
            zn_c = {zn_c[QW-2:0], 1'b0};
            if (za_c >= {1'b0, dsz_ff[g]}) begin
               za_c = za_c - {1'b0, dsz_ff[g]};
               zn_c[0] = 1'b1;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[g+1] <= 1'b0;
         end else if (en) begin
            dv_ff[g+1] <= dv_ff[g];
         end
         if (en) begin
            ra_ff[g+1] <= ra_c;
            za_ff[g+1] <= za_c;
            rn_ff[g+1] <= rn_c;
            zn_ff[g+1] <= zn_c;
            ds_ff[g+1] <= ds_ff[g];
            dsz_ff[g+1] <= dsz_ff[g];
         end
      end
   end

   // clamp stage
   logic vo_ff;
   logic [T_W-1:0] r_ff, rz_ff;
   logic [QW-1:0] rq, zq;
   logic [T_W-1:0] r_in, rz_in;

   always_comb begin
      rq = rn_ff[DIV_STAGES];
      zq = zn_ff[DIV_STAGES];
      r_in = ((ds_ff[DIV_STAGES] == '0) || (rq >= QW'(ONE_FX))) ? ONE_FX : T_W'(rq);
      rz_in = ((dsz_ff[DIV_STAGES] == '0) || (zq >= QW'(ONE_FX))) ? ONE_FX : T_W'(zq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (en) begin
         vo_ff <= dv_ff[DIV_STAGES];
      end
      if (en) begin
         r_ff <= r_in;
         rz_ff <= rz_in;
      end
   end

   assign out_valid = vo_ff;
   assign r_out = r_ff;
   assign rz_out = rz_ff;

`ifndef SYNTH
   a_r_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (r_out <= ONE_FX) && (rz_out <= ONE_FX))
      else $error("radius above one");
   a_valid_flow: assert property (@(posedge clock) disable iff (reset)
      !en |=> (out_valid == $past(out_valid)))
      else $error("valid moved during stall");
   a_depth: assert property (@(posedge clock) disable iff (reset)
      (en && dv_ff[DIV_STAGES]) |=> vo_ff)
      else $error("item lost at clamp stage");
`endif
endmodule

[src/wrbf_weight.sv]
// Pipelined evaluation of w(rz)*w(r), with the multiplies spread over the stages.
// Depends on wrbf_pkg.
module wrbf_weight import wrbf_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic in_valid,
   input  logic [T_W-1:0] r_in,
   input  logic [T_W-1:0] rz_in,
   output logic out_valid,
   output logic [OUT_W-1:0] value
);
   localparam int PW = FRAC_BITS + 6;
   localparam int WW = FRAC_BITS + 3;
   localparam int PR = 2 * T_W;

   // stage 1: u, u*u, t*t for both radii
   logic v1_ff;
   logic [T_W-1:0] ta1_ff, tb1_ff;
   logic [T_W-1:0] ua2_ff, ub2_ff, ta2_ff, tb2_ff;
   logic [T_W-1:0] ua, ub;
   logic [PR-1:0] pua, pub, pta, ptb;

   always_comb begin
      ua = ONE_FX - r_in;
      ub = ONE_FX - rz_in;
      pua = ua * ua;
      pub = ub * ub;
      pta = r_in * r_in;
      ptb = rz_in * rz_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
      end
      if (en) begin
         ta1_ff <= r_in;
         tb1_ff <= rz_in;
         ua2_ff <= T_W'(pua >> FRAC_BITS);
         ub2_ff <= T_W'(pub >> FRAC_BITS);
         ta2_ff <= T_W'(pta >> FRAC_BITS);
         tb2_ff <= T_W'(ptb >> FRAC_BITS);
      end
   end

   // stage 2: u4, t3
   logic v2_ff;
   logic [T_W-1:0] ta2b_ff, tb2b_ff, ta22_ff, tb22_ff;
   logic [T_W-1:0] ua4_ff, ub4_ff, ta3_ff, tb3_ff;
   logic [PR-1:0] p4a, p4b, p3a, p3b;

   always_comb begin
      p4a = ua2_ff * ua2_ff;
      p4b = ub2_ff * ub2_ff;
      p3a = ta2_ff * ta1_ff;
      p3b = tb2_ff * tb1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         ta2b_ff <= ta1_ff;
         tb2b_ff <= tb1_ff;
         ta22_ff <= ta2_ff;
         tb22_ff <= tb2_ff;
         ua4_ff <= T_W'(p4a >> FRAC_BITS);
         ub4_ff <= T_W'(p4b >> FRAC_BITS);
         ta3_ff <= T_W'(p3a >> FRAC_BITS);
         tb3_ff <= T_W'(p3b >> FRAC_BITS);
      end
   end

   // stage 3: polynomial sums
   logic v3_ff;
   logic [T_W-1:0] ua4b_ff, ub4b_ff;
   logic [PW-1:0] pa_ff, pb_ff;
   logic [PW-1:0] pa_in, pb_in;

   always_comb begin
      pa_in = PW'({ONE_FX, 2'b00}) + PW'({ta2b_ff, 4'b0000})
            + PW'(ta22_ff) * PW'(12) + PW'(ta3_ff) * PW'(3);
      pb_in = PW'({ONE_FX, 2'b00}) + PW'({tb2b_ff, 4'b0000})
            + PW'(tb22_ff) * PW'(12) + PW'(tb3_ff) * PW'(3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         ua4b_ff <= ua4_ff;
         ub4b_ff <= ub4_ff;
         pa_ff <= pa_in;
         pb_ff <= pb_in;
      end
   end

   // stage 4: weights
   logic v4_ff;
   logic [WW-1:0] wa_ff, wb_ff;
   logic [T_W+PW-1:0] qa, qb;

   always_comb begin
      qa = ua4b_ff * pa_ff;
      qb = ub4b_ff * pb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
      if (en) begin
         wa_ff <= WW'(qa >> FRAC_BITS);
         wb_ff <= WW'(qb >> FRAC_BITS);
      end
   end

   // stage 5: product and saturation
   logic v5_ff;
   logic [OUT_W-1:0] val_ff;
   logic [2*WW-1:0] qv;
   logic [2*WW-1:0] qs;
   logic [OUT_W-1:0] val_in;

   always_comb begin
      qv = wa_ff * wb_ff;
      qs = qv >> FRAC_BITS;
      val_in = (qs > (2*WW)'(OUT_MAX)) ? OUT_MAX : OUT_W'(qs);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
      if (en) begin
         val_ff <= val_in;
      end
   end

   assign out_valid = v5_ff;
   assign value = val_ff;

`ifndef SYNTH
   a_zero_edge: assert property (@(posedge clock) disable iff (reset)
      (en && v3_ff && (ua4b_ff == '0)) |=> (wa_ff == '0))
      else $error("weight not zero at edge");
   a_peak: assert property (@(posedge clock) disable iff (reset)
      v5_ff |-> (val_ff <= OUT_W'(1) << (FRAC_BITS + 4)))
      else $error("value above peak");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(val_ff))
      else $error("value moved during stall");
`endif
endmodule

[src/wu_rbf_kernel_sample_unit.sv]
// Throughput: one request per cycle; the pipe is offsets (1 stage), square root (6), dividers (6),
// clamp (1) and weight pipeline (5); a response stall halts the whole pipe.
// Reset: synchronous, active high; clears valid bits and sets support and
// support_z to 8.
// Depends on wrbf_pkg, wrbf_if, wrbf_radius, wrbf_weight.
module wu_rbf_kernel_sample_unit import wrbf_pkg::*; (
   input  logic clock,
   input  logic reset,
   wrbf_req_if.sink req,
   wrbf_rsp_if.source rsp,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [2:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);
   logic [SUP_W-1:0] support_ff, support_z_ff;
   logic en;
   logic rad_valid, out_valid;
   logic [T_W-1:0] r, rz;
   logic [OUT_W-1:0] value;
   logic wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite && (csr_paddr[1:0] == 2'b00);

   always_ff @(posedge clock) begin
      if (reset) begin
         support_ff <= SUP_W'(8);
         support_z_ff <= SUP_W'(8);
      end else if (wr && csr_paddr[2] == REG_SUPPORT) begin
         support_ff <= csr_pwdata[SUP_W-1:0];
      end else if (wr && csr_paddr[2] == REG_SUPPORT_Z) begin
         support_z_ff <= csr_pwdata[SUP_W-1:0];
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_SUPPORT:   csr_prdata = 32'(support_ff);
         REG_SUPPORT_Z: csr_prdata = 32'(support_z_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign en = !out_valid || rsp.ready;
   assign req.ready = en && !reset;

   wrbf_radius u_radius (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req.valid), .in_data(req.data),
      .support(support_ff), .support_z(support_z_ff),
      .out_valid(rad_valid), .r_out(r), .rz_out(rz)
   );

   wrbf_weight u_weight (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(rad_valid), .r_in(r), .rz_in(rz),
      .out_valid(out_valid), .value(value)
   );

   assign rsp.valid = out_valid;
   assign rsp.data.kernel_value = value;
endmodule
